// ===== hw/rtl/button_event_tracker_core_defines.svh =====
// ----------------------------------------------------------------------------
// Button event tracker assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef BUTTON_EVENT_TRACKER_CORE_DEFINES_SVH
`define BUTTON_EVENT_TRACKER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Assertion checked on every rising clock edge outside reset.
`define BET_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("button event tracker assertion failed");
// Assertion checked on every rising clock edge, reset included.
`define BET_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("button event tracker assertion failed");
`else
`define BET_ASSERT(lbl, clk, rst_n, prop)
`define BET_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== hw/rtl/bet_pkg.sv =====
// ----------------------------------------------------------------------------
// Button event tracker package
// Shared types, codes and the timer check of the button event tracker.
// ----------------------------------------------------------------------------
package bet_pkg;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_READ   = 2'd1,
    CMD_PEEK   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_BUTTON_COUNT  = 2'd0,
    CFG_PRESS_SPAN    = 2'd1,
    CFG_RELEASE_SPAN  = 2'd2
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [3:0]  CountReset       = 4'd0;
  localparam logic [15:0] PressSpanReset   = 16'd100;
  localparam logic [15:0] ReleaseSpanReset = 16'd300;

  // One table entry.
  typedef struct packed {
    logic        down;
    logic        pressed;
    logic        released;
    logic [31:0] start_time;
    logic [15:0] press_stamp;
    logic [15:0] release_stamp;
  } entry_t;

  // One result word.
  typedef struct packed {
    logic        is_down;
    logic        is_pressed;
    logic        is_released;
    logic [31:0] held_ms;
    logic        input_changed;
    logic        known_button;
  } res_t;

  // A span is up once the 16-bit wrapped elapsed time reaches it.
  function automatic logic span_up(logic [15:0] stamp, logic [15:0] now16,
                                   logic [15:0] span);
    logic [15:0] elapsed;
    elapsed = now16 - stamp;
    return elapsed >= span;
  endfunction

endpackage

// ===== hw/rtl/bet_in_if.sv =====
// ----------------------------------------------------------------------------
// Button event tracker input channel
// Valid/ready channel that carries one command word.
// ----------------------------------------------------------------------------
interface bet_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  btn_id;
  logic        pin_level;
  logic [31:0] now_ms;

  modport source (output valid, command, btn_id, pin_level, now_ms, input ready);
  modport sink   (input valid, command, btn_id, pin_level, now_ms, output ready);
endinterface

// ===== hw/rtl/bet_out_if.sv =====
// ----------------------------------------------------------------------------
// Button event tracker output channel
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface bet_out_if;
  logic        valid;
  logic        ready;
  logic        is_down;
  logic        is_pressed;
  logic        is_released;
  logic [31:0] held_ms;
  logic        input_changed;
  logic        known_button;

  modport source (output valid, is_down, is_pressed, is_released, held_ms,
                  input_changed, known_button, input ready);
  modport sink   (input valid, is_down, is_pressed, is_released, held_ms,
                  input_changed, known_button, output ready);
endinterface

// ===== hw/rtl/bet_update.sv =====
// ----------------------------------------------------------------------------
// Button event tracker entry update
// Computes the new table entry and the result word for one command.
// ----------------------------------------------------------------------------
module bet_update import bet_pkg::*; (
  input  entry_t      entry_i,
  input  cmd_e        cmd_i,
  input  logic        pin_i,
  input  logic [31:0] now_i,
  input  logic [15:0] press_span_i,
  input  logic [15:0] release_span_i,
  output entry_t      entry_o,
  output res_t        res_o
);

  entry_t     e;
  logic       changed;
  logic [15:0] now16;

  assign now16 = now_i[15:0];

  always_comb begin
    e       = entry_i;
    changed = 1'b0;
    unique case (cmd_i)
      CMD_SAMPLE: begin
        if (pin_i) begin
          if (!e.down) begin
            e.down          = 1'b1;
            e.start_time    = now_i;
            e.pressed       = 1'b1;
            e.press_stamp   = now16;
            e.released      = 1'b0;
            e.release_stamp = '0;
            changed         = 1'b1;
          end
          // A zero span lets a fresh press expire on the sample that raised it.
          if (e.pressed && span_up(e.press_stamp, now16, press_span_i)) begin
            e.pressed = 1'b0;
          end
        end else begin
          if (e.down && !e.released) begin
            e.released      = 1'b1;
            e.release_stamp = now16;
            changed         = 1'b1;
          end else if (e.released && span_up(e.release_stamp, now16, release_span_i)) begin
            e.released      = 1'b0;
            e.release_stamp = '0;
          end
          e.down        = 1'b0;
          e.pressed     = 1'b0;
          e.press_stamp = '0;
          e.start_time  = '0;
        end
      end
      default: begin
        // Read and peek report the stored entry as it is.
      end
    endcase
  end

  always_comb begin
    res_o.is_down       = e.down;
    res_o.is_pressed    = e.pressed;
    res_o.is_released   = e.released;
    res_o.held_ms       = e.down ? (now_i - e.start_time) : 32'd0;
    res_o.input_changed = changed;
    res_o.known_button  = 1'b1;
  end

  // A read clears the pending events after reporting them.
  always_comb begin
    entry_o = e;
    if (cmd_i == CMD_READ) begin
      entry_o.pressed  = 1'b0;
      entry_o.released = 1'b0;
    end
  end

endmodule

// ===== hw/rtl/button_event_tracker_core.sv =====
// Pipeline: two stages; an accepted input word is held in stage one, and its result word
// is registered into the output register, where it is held until it is taken.
// Throughput: one word per cycle while results are taken; the table is a one-port-read,
// one-port-write memory with a registered read, and the last write is forwarded so
// words on the same button may follow each other back to back.
// Reset: control state and per-entry valid bits clear at once, so there is no
// clearing pass; an entry that is not valid reads as all zero.
// ----------------------------------------------------------------------------
// Button event tracker core
// Table of button states updated by sample, read and peek commands.
// ----------------------------------------------------------------------------
`include "button_event_tracker_core_defines.svh"

module button_event_tracker_core import bet_pkg::*; #(
  parameter int unsigned MAX_BUTTONS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  bet_in_if.sink              in_i,
  bet_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned IdxW = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
  localparam logic [7:0]  MaxB = 8'(MAX_BUTTONS);

  // Configuration registers.
  logic [3:0]  count_q;
  logic [15:0] press_span_q, release_span_q;

  // Table memory and its valid bits.
  entry_t                 mem [MAX_BUTTONS];
  entry_t                 rdata_q;
  logic [MAX_BUTTONS-1:0] entry_valid_q;

  // Stage one.
  logic            s1_valid_q;
  logic            s1_known_q;
  logic [IdxW-1:0] s1_idx_q;
  cmd_e            s1_cmd_q;
  logic            s1_pin_q;
  logic [31:0]     s1_now_q;

  // Forwarding of the last write.
  logic            fwd_valid_q, fwd_valid_d;
  logic [IdxW-1:0] fwd_idx_q;
  entry_t          fwd_data_q;

  // Output register.
  logic out_valid_q;
  res_t out_q;

  logic [7:0]      live_n, new_n, keep_n;
  logic            in_known;
  logic [IdxW-1:0] in_idx;
  logic            in_accept, can_adv, s1_adv, mem_we;
  entry_t          cur_entry, new_entry;
  res_t            upd_res, s1_res;

  // Entries beyond the table are never registered.
  assign live_n = (8'(count_q) > MaxB) ? MaxB : 8'(count_q);
  assign new_n  = (8'(cfg_wdata_i[3:0]) > MaxB) ? MaxB : 8'(cfg_wdata_i[3:0]);
  assign keep_n = (live_n < new_n) ? live_n : new_n;

  assign in_known  = (in_i.btn_id != 8'd0) && (in_i.btn_id <= live_n);
  assign in_idx    = IdxW'(in_i.btn_id - 8'd1);
  assign can_adv   = !out_valid_q || out_o.ready;
  assign in_i.ready = can_adv;
  assign in_accept = in_i.valid && can_adv;
  assign s1_adv    = s1_valid_q && can_adv;
  assign mem_we    = s1_adv && s1_known_q;

  always_comb begin
    if (fwd_valid_q) begin
      cur_entry = fwd_data_q;
    end else if (entry_valid_q[s1_idx_q]) begin
      cur_entry = rdata_q;
    end else begin
      cur_entry = '0;
    end
  end

  bet_update u_update (
    .entry_i        (cur_entry),
    .cmd_i          (s1_cmd_q),
    .pin_i          (s1_pin_q),
    .now_i          (s1_now_q),
    .press_span_i   (press_span_q),
    .release_span_i (release_span_q),
    .entry_o        (new_entry),
    .res_o          (upd_res)
  );

  assign s1_res = s1_known_q ? upd_res : '0;

  // The stored entry is forwarded when the next word reads it in the same cycle.
  always_comb begin
    if (in_accept) begin
      fwd_valid_d = mem_we && in_known && (s1_idx_q == in_idx);
    end else if (s1_adv) begin
      fwd_valid_d = 1'b0;
    end else begin
      fwd_valid_d = fwd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[s1_idx_q] <= new_entry;
    end
    if (in_accept && in_known) begin
      rdata_q <= mem[in_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= CountReset;
      press_span_q   <= PressSpanReset;
      release_span_q <= ReleaseSpanReset;
      entry_valid_q  <= '0;
    end else begin
      if (mem_we) begin
        entry_valid_q[s1_idx_q] <= 1'b1;
      end
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          CFG_BUTTON_COUNT: begin
            count_q <= cfg_wdata_i[3:0];
            for (int i = 0; i < MAX_BUTTONS; i++) begin
              if (8'(i) >= keep_n) begin
                entry_valid_q[i] <= 1'b0;
              end
            end
          end
          CFG_PRESS_SPAN:   press_span_q   <= cfg_wdata_i;
          CFG_RELEASE_SPAN: release_span_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= fwd_valid_d;
      if (can_adv) begin
        s1_valid_q  <= in_i.valid;
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_known_q <= in_known;
      s1_idx_q   <= in_idx;
      s1_cmd_q   <= cmd_e'(in_i.command);
      s1_pin_q   <= in_i.pin_level;
      s1_now_q   <= in_i.now_ms;
      fwd_idx_q  <= s1_idx_q;
      fwd_data_q <= new_entry;
    end
    if (s1_adv) begin
      out_q <= s1_res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.is_down       = out_q.is_down;
  assign out_o.is_pressed    = out_q.is_pressed;
  assign out_o.is_released   = out_q.is_released;
  assign out_o.held_ms       = out_q.held_ms;
  assign out_o.input_changed = out_q.input_changed;
  assign out_o.known_button  = out_q.known_button;

  // Forwarded data always belongs to the entry that stage one holds.
  `BET_ASSERT(a_fwd_match, clk_i, rst_ni, fwd_valid_q |-> (s1_valid_q && s1_known_q && fwd_idx_q == s1_idx_q))
  // An unknown button yields an all-zero result.
  `BET_ASSERT(a_unknown_zero, clk_i, rst_ni, (s1_adv && !s1_known_q) |=> (out_q == '0))
  // Unregistering every button invalidates the whole table.
  `BET_ASSERT(a_cfg_clear, clk_i, rst_ni, (cfg_we_i && cfg_idx_i == CFG_BUTTON_COUNT && cfg_wdata_i[3:0] == 4'd0) |=> (entry_valid_q == '0))

endmodule
